>>> sv/lcdtnw_pkg.sv
// Shared types, codes and constants for the character LCD nibble writer.
package lcdtnw_pkg;

  localparam int unsigned COL_W  = 6;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned TROW_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_CURSOR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CMD    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd1;

  localparam logic [COL_W-1:0] COLUMN_COUNT_RST = 6'd16;
  localparam logic [ROW_W-1:0] ROW_COUNT_RST    = 3'd2;

  // Register select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Special characters and the set-address command
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;

  // DDRAM start address of each display row
  localparam logic [BYTE_W-1:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  // One or two bytes produced by an item, high nibble goes out first
  typedef struct packed {
    logic              two;
    logic [BYTE_W-1:0] byte0;
    logic              rs0;
    logic [BYTE_W-1:0] byte1;
    logic              rs1;
  } xfer_pair_t;

endpackage

>>> sv/lcdtnw_calc.sv
// Per-item decode: cursor tracking and the bytes one item sends.
module lcdtnw_calc (
  input  logic [lcdtnw_pkg::MODE_W-1:0] mode,
  input  logic [lcdtnw_pkg::BYTE_W-1:0] byte_value,
  input  logic [lcdtnw_pkg::COL_W-1:0]  target_col,
  input  logic [lcdtnw_pkg::TROW_W-1:0] target_row,
  input  logic [lcdtnw_pkg::COL_W-1:0]  cursor_col,
  input  logic [lcdtnw_pkg::ROW_W-1:0]  cursor_row,
  input  logic [lcdtnw_pkg::COL_W-1:0]  column_count,
  input  logic [lcdtnw_pkg::ROW_W-1:0]  row_count,
  output lcdtnw_pkg::xfer_pair_t        pair,
  output logic                          none,
  output logic [lcdtnw_pkg::COL_W-1:0]  new_col,
  output logic [lcdtnw_pkg::ROW_W-1:0]  new_row
);

  // Rows at or beyond the row count fold back to row 0.
  function automatic logic [lcdtnw_pkg::ROW_W-1:0] map_row(
    input logic [lcdtnw_pkg::ROW_W:0]   r,
    input logic [lcdtnw_pkg::ROW_W-1:0] cnt
  );
    map_row = (r >= {1'b0, cnt}) ? '0 : r[lcdtnw_pkg::ROW_W-1:0];
  endfunction

  function automatic logic [lcdtnw_pkg::BYTE_W-1:0] addr_cmd(
    input logic [lcdtnw_pkg::COL_W-1:0] c,
    input logic [lcdtnw_pkg::ROW_W-1:0] r
  );
    addr_cmd = lcdtnw_pkg::CMD_SET_ADDR
             | ({2'b00, c} + lcdtnw_pkg::ROW_OFFSET[r[1:0]]);
  endfunction

  logic                         wrap;
  logic [lcdtnw_pkg::ROW_W-1:0] row_wrap;
  logic [lcdtnw_pkg::COL_W-1:0] col1;
  logic [lcdtnw_pkg::ROW_W-1:0] row1;
  logic [lcdtnw_pkg::ROW_W-1:0] row_lf;
  logic [lcdtnw_pkg::ROW_W-1:0] row_cr;
  logic [lcdtnw_pkg::ROW_W-1:0] row_set;

  assign wrap     = (cursor_col >= column_count);
  assign row_wrap = map_row({1'b0, cursor_row} + 4'd1, row_count);
  assign col1     = wrap ? '0 : cursor_col;
  assign row1     = wrap ? row_wrap : cursor_row;
  assign row_lf   = map_row({1'b0, row1} + 4'd1, row_count);
  assign row_cr   = map_row({1'b0, row1}, row_count);
  assign row_set  = map_row({2'b00, target_row}, row_count);

  always_comb begin
    logic [lcdtnw_pkg::BYTE_W-1:0] b2;
    logic                          rs2;
    pair    = '0;
    none    = 1'b0;
    new_col = cursor_col;
    new_row = cursor_row;
    b2      = byte_value;
    rs2     = lcdtnw_pkg::RS_DATA;
    unique case (mode)
      lcdtnw_pkg::MODE_CURSOR: begin
        new_col    = target_col;
        new_row    = row_set;
        pair.byte0 = addr_cmd(target_col, row_set);
        pair.rs0   = lcdtnw_pkg::RS_CMD;
      end
      lcdtnw_pkg::MODE_TEXT: begin
        if (byte_value == lcdtnw_pkg::CHAR_NUL) begin
          none = 1'b1;
        end else begin
          if (byte_value == lcdtnw_pkg::CHAR_LF) begin
            b2      = addr_cmd(col1, row_lf);
            rs2     = lcdtnw_pkg::RS_CMD;
            new_col = col1;
            new_row = row_lf;
          end else if (byte_value == lcdtnw_pkg::CHAR_CR) begin
            b2      = addr_cmd('0, row_cr);
            rs2     = lcdtnw_pkg::RS_CMD;
            new_col = '0;
            new_row = row_cr;
          end else begin
            new_col = col1 + 6'd1;
            new_row = row1;
          end
          // A wrap first repositions the cursor, then the character follows.
          if (wrap) begin
            pair.two   = 1'b1;
            pair.byte0 = addr_cmd('0, row_wrap);
            pair.rs0   = lcdtnw_pkg::RS_CMD;
            pair.byte1 = b2;
            pair.rs1   = rs2;
          end else begin
            pair.byte0 = b2;
            pair.rs0   = rs2;
          end
        end
      end
      lcdtnw_pkg::MODE_CMD: begin
        pair.byte0 = byte_value;
        pair.rs0   = lcdtnw_pkg::RS_CMD;
      end
      lcdtnw_pkg::MODE_DATA: begin
        pair.byte0 = byte_value;
        pair.rs0   = lcdtnw_pkg::RS_DATA;
      end
    endcase
  end

endmodule

>>> sv/lcdtnw_serializer.sv
// Result register that splits one or two bytes into nibble transfers.
module lcdtnw_serializer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  lcdtnw_pkg::xfer_pair_t pair,
  output logic                   free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [3:0] nibble_value, [7:4] zero
  output logic                   out_tuser,  // [0] register_select
  output logic                   out_tlast   // last_of_item
);

  logic                          valid_r;
  logic [1:0]                    idx_r;
  logic                          two_r;
  logic [lcdtnw_pkg::BYTE_W-1:0] byte0_r;
  logic                          rs0_r;
  logic [lcdtnw_pkg::BYTE_W-1:0] byte1_r;
  logic                          rs1_r;
  logic [lcdtnw_pkg::BYTE_W-1:0] cur_byte;
  logic [lcdtnw_pkg::NIB_W-1:0]  nibble;

  // idx_r[1] selects the byte, idx_r[0] the nibble (high first).
  assign cur_byte   = idx_r[1] ? byte1_r : byte0_r;
  assign nibble     = idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0000, nibble};
  assign out_tuser  = idx_r[1] ? rs1_r : rs0_r;
  assign out_tlast  = idx_r[0] && (idx_r[1] == two_r);
  assign free       = !valid_r || (out_tready && out_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (valid_r && out_tready) begin
      if (out_tlast) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      two_r   <= pair.two;
      byte0_r <= pair.byte0;
      rs0_r   <= pair.rs0;
      byte1_r <= pair.byte1;
      rs1_r   <= pair.rs1;
    end
  end

endmodule

>>> sv/lcd_text_nibble_writer_unit.sv
// Top level of the character LCD 4-bit nibble writer.
// Each accepted request becomes 4-bit LCD bus transfers, high nibble first, with
// register select on out_tuser and out_tlast on the final transfer of the request.
// Mode 0 sets the cursor, mode 1 writes a text character (wrap at column_count,
// newline, carriage return; a zero byte ends a string and emits nothing), modes 2
// and 3 send a raw command or data byte. A request is held in an input register,
// decoded in one pass against the cursor, and handed to a result register that
// shifts out one nibble per cycle while out_tready is high. The input register
// holds the next request while the result register is still shifting out the
// previous one. The first nibble is presented once the request has passed
// through the input register and the result register. cfg_ready is always high;
// write registers only while the block is idle.
module lcd_text_nibble_writer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [lcdtnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdtnw_pkg::CFG_DATA_W-1:0] cfg_data,
  // Request stream
  input  logic       in_tvalid,
  output logic       in_tready,
  // [1:0] mode, [9:2] byte_value, [15:10] target_col, [17:16] target_row, [23:18] zero
  input  logic [23:0] in_tdata,
  // Transfer stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] nibble_value, [7:4] zero
  output logic       out_tuser,  // [0] register_select
  output logic       out_tlast   // last_of_item
);

  logic                          inq_valid_r;
  logic [lcdtnw_pkg::MODE_W-1:0] inq_mode_r;
  logic [lcdtnw_pkg::BYTE_W-1:0] inq_byte_r;
  logic [lcdtnw_pkg::COL_W-1:0]  inq_col_r;
  logic [lcdtnw_pkg::TROW_W-1:0] inq_row_r;

  logic [lcdtnw_pkg::COL_W-1:0]  cursor_col_r;
  logic [lcdtnw_pkg::ROW_W-1:0]  cursor_row_r;
  logic [lcdtnw_pkg::COL_W-1:0]  cursor_col_nxt;
  logic [lcdtnw_pkg::ROW_W-1:0]  cursor_row_nxt;
  logic [lcdtnw_pkg::COL_W-1:0]  column_count_r;
  logic [lcdtnw_pkg::ROW_W-1:0]  row_count_r;

  lcdtnw_pkg::xfer_pair_t        pair;
  logic                          none;
  logic                          ser_free;
  logic                          ser_load;
  logic                          inq_move;
  logic                          in_acc;

  // Advance the held request once the result register can take it; a zero
  // byte produces nothing and may pass at any time.
  assign inq_move  = inq_valid_r && (none || ser_free);
  assign ser_load  = inq_move && !none;
  assign in_tready = !inq_valid_r || inq_move;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_tready) begin
      inq_valid_r <= in_tvalid;
    end
  end

  // Hold the request payload; capture a new one on accept.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      inq_mode_r <= in_tdata[1:0];
      inq_byte_r <= in_tdata[9:2];
      inq_col_r  <= in_tdata[15:10];
      inq_row_r  <= in_tdata[17:16];
    end
  end

  // Cursor advances exactly when its request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
    end else if (inq_move) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= lcdtnw_pkg::COLUMN_COUNT_RST;
      row_count_r    <= lcdtnw_pkg::ROW_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcdtnw_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_data;
        lcdtnw_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_data[2:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  lcdtnw_calc u_calc (
    .mode         (inq_mode_r),
    .byte_value   (inq_byte_r),
    .target_col   (inq_col_r),
    .target_row   (inq_row_r),
    .cursor_col   (cursor_col_r),
    .cursor_row   (cursor_row_r),
    .column_count (column_count_r),
    .row_count    (row_count_r),
    .pair         (pair),
    .none         (none),
    .new_col      (cursor_col_nxt),
    .new_row      (cursor_row_nxt)
  );

  lcdtnw_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ser_load),
    .pair       (pair),
    .free       (ser_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  // A request never overwrites a result still being shifted out.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |-> ser_free)
    else $error("result register loaded while busy");

  // A loaded result shows up on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |=> out_tvalid)
    else $error("loaded result not presented");

  // Cursor changes only when a request leaves the input register.
  a_cursor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !inq_move |=> $stable(cursor_col_r) && $stable(cursor_row_r))
    else $error("cursor moved without a request");
`endif

endmodule

>>> bench/lcd_text_nibble_writer_unit_tb.sv
// Self-checking testbench for the character LCD nibble writer top level.
module lcd_text_nibble_writer_unit_tb;

  // Run limits: the watchdog is far above the slowest legal run, which is
  // roughly 230 requests x 4 transfers with a 6% output stall plus one
  // hold-off of HOLD_CYCLES.
  localparam int unsigned WATCHDOG_CYCLES = 60000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned IDLE_PERCENT    = 6;
  localparam int unsigned WARMUP_REQS     = 20;
  localparam int unsigned PHASE_REQS      = 30;

  // One request, as it is packed on in_tdata
  typedef struct packed {
    logic [lcdtnw_pkg::MODE_W-1:0] mode;
    logic [lcdtnw_pkg::BYTE_W-1:0] chr;
    logic [lcdtnw_pkg::COL_W-1:0]  tcol;
    logic [lcdtnw_pkg::TROW_W-1:0] trow;
  } lcd_req_t;

  // One bus transfer on the output stream
  typedef struct packed {
    logic [lcdtnw_pkg::NIB_W-1:0] nib;
    logic                         rs;
    logic                         last;
  } lcd_xfer_t;

  // Directed row: the request, and where the answer is obvious, the byte it
  // must produce (one_byte 0 means the request emits nothing at all)
  typedef struct packed {
    lcd_req_t                      req;
    logic                          typed;
    logic                          one_byte;
    logic [lcdtnw_pkg::BYTE_W-1:0] exp_byte;
    logic                          exp_rs;
  } dir_row_t;

  // Directed rows run at the reset setting: 16 columns, 2 rows, cursor home.
  localparam int unsigned NDIR = 22;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    // raw bytes at both extremes and an alternating pattern
    '{'{lcdtnw_pkg::MODE_CMD,    8'h00, 6'd0,  2'd0}, 1'b1, 1'b1, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CMD,    8'hFF, 6'd63, 2'd3}, 1'b1, 1'b1, 8'hFF, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CMD,    8'h5A, 6'd0,  2'd0}, 1'b1, 1'b1, 8'h5A, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_DATA,   8'h00, 6'd0,  2'd0}, 1'b1, 1'b1, 8'h00, lcdtnw_pkg::RS_DATA},
    '{'{lcdtnw_pkg::MODE_DATA,   8'hFF, 6'd0,  2'd0}, 1'b1, 1'b1, 8'hFF, lcdtnw_pkg::RS_DATA},
    '{'{lcdtnw_pkg::MODE_DATA,   8'hA5, 6'd21, 2'd2}, 1'b1, 1'b1, 8'hA5, lcdtnw_pkg::RS_DATA},
    // cursor set: home, last column on row 1, row beyond row count, column 15
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'hFF, 6'd0,  2'd0}, 1'b1, 1'b1, 8'h80, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'h00, 6'd39, 2'd1}, 1'b1, 1'b1, 8'hE7, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'h00, 6'd63, 2'd3}, 1'b1, 1'b1, 8'hBF, lcdtnw_pkg::RS_CMD},
    // zero byte ends a string and emits nothing
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h00, 6'd63, 2'd3}, 1'b1, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    // column already past the count: wrap, then the character
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h41, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'h00, 6'd15, 2'd0}, 1'b1, 1'b1, 8'h8F, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h5A, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'hFF, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    // newline off the last row, then carriage return
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h0A, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h0D, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    // newline and carriage return right at the wrap point
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'h00, 6'd16, 2'd1}, 1'b1, 1'b1, 8'hD0, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h0A, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_CURSOR, 8'h00, 6'd20, 2'd0}, 1'b1, 1'b1, 8'h94, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h0D, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h7F, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD},
    '{'{lcdtnw_pkg::MODE_TEXT,   8'h80, 6'd0,  2'd0}, 1'b0, 1'b0, 8'h00, lcdtnw_pkg::RS_CMD}
  };

  // Register settings per phase; a negative entry means pick at random.
  // Zero counts and counts above the display range are reachable through
  // the register widths, so they are exercised too.
  localparam int unsigned NPHASE = 6;
  localparam int PHASE_COLS [NPHASE] = '{1, 40, 0, 63, -1, 5};
  localparam int PHASE_ROWS [NPHASE] = '{1, 4,  0, 7,  -1, 3};
  localparam int unsigned STEADY_PHASE   = 1;
  localparam int unsigned PRESSURE_PHASE = 3;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lcdtnw_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lcdtnw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [23:0]                       in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b1;
  logic [7:0]                        out_tdata;
  logic                              out_tuser;
  logic                              out_tlast;

  // Predictor state: display geometry and cursor
  logic [lcdtnw_pkg::COL_W-1:0] disp_cols = lcdtnw_pkg::COLUMN_COUNT_RST;
  logic [lcdtnw_pkg::ROW_W-1:0] disp_rows = lcdtnw_pkg::ROW_COUNT_RST;
  logic [lcdtnw_pkg::COL_W-1:0] cur_col = '0;
  logic [lcdtnw_pkg::ROW_W-1:0] cur_row = '0;

  lcd_xfer_t item_xfers[$];     // transfers of the request just accepted
  lcd_xfer_t pending_xfers[$];  // transfers still owed by the block

  bit          steady = 1'b0;      // no idling on either side
  bit          stall_req = 1'b0;   // ask the receiver for one long hold-off
  int unsigned fail_count = 0;
  int unsigned req_count = 0;
  int unsigned xfer_count = 0;
  int unsigned wrap_count = 0;
  int unsigned cycle_count = 0;

  lcd_text_nibble_writer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Split a byte into two transfers, high nibble first
  task automatic queue_byte(input logic [lcdtnw_pkg::BYTE_W-1:0] b, input logic rs);
    item_xfers.push_back('{b[7:4], rs, 1'b0});
    item_xfers.push_back('{b[3:0], rs, 1'b0});
  endtask

  // Move the cursor and emit the set-address command. The row comes in one
  // bit wider so that an advanced row never wraps before the compare.
  task automatic place_cursor(input logic [lcdtnw_pkg::COL_W-1:0] col,
                              input logic [lcdtnw_pkg::ROW_W:0]   row);
    logic [lcdtnw_pkg::BYTE_W-1:0] addr;
    if (row >= {1'b0, disp_rows}) row = '0;
    cur_col = col;
    cur_row = row[lcdtnw_pkg::ROW_W-1:0];
    addr = lcdtnw_pkg::CMD_SET_ADDR | (8'(cur_col) + lcdtnw_pkg::ROW_OFFSET[cur_row[1:0]]);
    queue_byte(addr, lcdtnw_pkg::RS_CMD);
  endtask

  task automatic predict_transfers(input lcd_req_t r);
    item_xfers.delete();
    case (r.mode)
      lcdtnw_pkg::MODE_CURSOR: begin
        place_cursor(r.tcol, {2'b00, r.trow});
      end
      lcdtnw_pkg::MODE_TEXT: begin
        if (r.chr != lcdtnw_pkg::CHAR_NUL) begin
          // wrap first when the row is already full
          if (cur_col >= disp_cols) begin
            place_cursor('0, {1'b0, cur_row} + 4'd1);
            wrap_count++;
          end
          if (r.chr == lcdtnw_pkg::CHAR_LF) begin
            place_cursor(cur_col, {1'b0, cur_row} + 4'd1);
          end else if (r.chr == lcdtnw_pkg::CHAR_CR) begin
            place_cursor('0, {1'b0, cur_row});
          end else begin
            queue_byte(r.chr, lcdtnw_pkg::RS_DATA);
            cur_col = cur_col + 6'd1;
          end
        end
      end
      lcdtnw_pkg::MODE_CMD: begin
        queue_byte(r.chr, lcdtnw_pkg::RS_CMD);
      end
      default: begin
        queue_byte(r.chr, lcdtnw_pkg::RS_DATA);
      end
    endcase
  endtask

  // Flag the final transfer of the request and hand everything to the scoreboard
  task automatic commit_item();
    lcd_xfer_t tail;
    if (item_xfers.size() != 0) begin
      tail = item_xfers.pop_back();
      tail.last = 1'b1;
      item_xfers.push_back(tail);
    end
    foreach (item_xfers[k]) pending_xfers.push_back(item_xfers[k]);
  endtask

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Drop valid now and then, never in a steady stretch
  task automatic sender_gap();
    if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Offer one request, hold it until accepted, then predict its transfers
  task automatic send_request(input lcd_req_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, r.trow, r.tcol, r.chr, r.mode};
    do @(posedge clk); while (!in_tready);
    predict_transfers(r);
    req_count++;
  endtask

  // Write one register; the caller drops cfg_valid after its last write
  task automatic write_register(input logic [lcdtnw_pkg::CFG_IDX_W-1:0]  idx,
                                input logic [lcdtnw_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lcdtnw_pkg::CFG_COLUMN_COUNT) disp_cols = value;
    else disp_rows = value[lcdtnw_pkg::ROW_W-1:0];
  endtask

  // Text dominates, with plenty of newlines, returns and string ends so the
  // cursor walks through wraps and row changes; the rest places the cursor
  // or sends raw bytes.
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int unsigned pick;
    pick   = $urandom_range(99);
    r.tcol = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
    r.trow = 2'($urandom_range(3));
    r.chr  = 8'($urandom_range(255));
    if (pick < 20) begin
      r.mode = lcdtnw_pkg::MODE_CURSOR;
    end else if (pick < 70) begin
      r.mode = lcdtnw_pkg::MODE_TEXT;
      pick = $urandom_range(99);
      if (pick < 8) r.chr = lcdtnw_pkg::CHAR_NUL;
      else if (pick < 23) r.chr = lcdtnw_pkg::CHAR_LF;
      else if (pick < 33) r.chr = lcdtnw_pkg::CHAR_CR;
      else if (pick < 60) r.chr = 8'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 85) begin
      r.mode = lcdtnw_pkg::MODE_CMD;
    end else begin
      r.mode = lcdtnw_pkg::MODE_DATA;
    end
    return r;
  endfunction

  task automatic random_burst(input int unsigned count);
    repeat (count) begin
      sender_gap();
      send_request(random_request());
      commit_item();
    end
    in_tvalid <= 1'b0;
  endtask

  // Wait for every owed transfer, then give a zero-byte request time to retire
  task automatic drain();
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor and scoreboard
  // ---------------------------------------------------------------------
  initial begin
    lcd_xfer_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        xfer_count++;
        if (pending_xfers.size() == 0) begin
          $display("%0t: transfer with none expected: nibble %h rs %b last %b",
                   $time, out_tdata[3:0], out_tuser, out_tlast);
          fail_count++;
        end else begin
          want = pending_xfers.pop_front();
          if (out_tdata[3:0] !== want.nib) begin
            $display("%0t: nibble expected %h actual %h", $time, want.nib, out_tdata[3:0]);
            fail_count++;
          end
          if (out_tuser !== want.rs) begin
            $display("%0t: register select expected %b actual %b", $time, want.rs, out_tuser);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last flag expected %b actual %b", $time, want.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run timed out with %0d transfers outstanding", $time, pending_xfers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int cols;
    int rows;
    // hold reset, then release it once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at the reset geometry; typed rows carry their own answer,
    // the predictor still runs so the cursor stays in step
    foreach (DIR_TAB[i]) begin
      sender_gap();
      send_request(DIR_TAB[i].req);
      if (DIR_TAB[i].typed) begin
        item_xfers.delete();
        if (DIR_TAB[i].one_byte) queue_byte(DIR_TAB[i].exp_byte, DIR_TAB[i].exp_rs);
      end
      commit_item();
    end
    random_burst(WARMUP_REQS);
    drain();

    // Walk the register settings, extremes included
    for (int unsigned p = 0; p < NPHASE; p++) begin
      cols = (PHASE_COLS[p] < 0) ? int'($urandom_range(63)) : PHASE_COLS[p];
      rows = (PHASE_ROWS[p] < 0) ? int'($urandom_range(7)) : PHASE_ROWS[p];
      steady = (p == STEADY_PHASE);
      write_register(lcdtnw_pkg::CFG_COLUMN_COUNT, 6'(cols));
      // upper data bits are junk for the row register and must be ignored
      write_register(lcdtnw_pkg::CFG_ROW_COUNT, {3'($urandom_range(7)), 3'(rows)});
      cfg_valid <= 1'b0;
      // hold off the receiver so the block backs up into its input
      if (p == PRESSURE_PHASE) stall_req = 1'b1;
      random_burst(PHASE_REQS);
      drain();
      steady = 1'b0;
    end

    if (pending_xfers.size() != 0) begin
      $display("%0t: %0d expected transfers never arrived", $time, pending_xfers.size());
      fail_count += pending_xfers.size();
    end
    $display("Sent %0d requests (%0d with a row wrap) over %0d register settings;",
             req_count, wrap_count, NPHASE + 1);
    $display("checked %0d nibble transfers, with one long output hold-off.", xfer_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
